### hdl/display_list_vertex_byte_inserter_assert.svh
// Assertion macros shared by the display list vertex byte inserter modules.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the asynchronous reset is active.
`ifndef DISPLAY_LIST_VERTEX_BYTE_INSERTER_ASSERT_SVH
`define DISPLAY_LIST_VERTEX_BYTE_INSERTER_ASSERT_SVH

// Plain property that must hold at every clock edge out of reset
`define DLV_ASSERT(lbl, clk, rstn, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked in the same cycle
`define DLV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/dlvbi_pkg.sv
// ----------------------------------------------------------------------------
// dlvbi_pkg
// Shared types and constants of the display list vertex byte inserter.
// ----------------------------------------------------------------------------
package dlvbi_pkg;

	// Default output alignment in bytes
	localparam int ALIGN_BYTES_DEF = 32;

	// Register FIFO between parser and output sequencer
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Register reset values
	localparam logic [7:0] STRIDE_RST = 8'd1;
	localparam logic [7:0] OFFSET_RST = 8'd0;
	localparam logic [7:0] BASE_RST   = 8'd0;
	localparam logic [7:0] FAN_RST    = 8'd160;
	localparam logic [7:0] STRIP_RST  = 8'd152;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_STRIDE = 3'd0,
		REG_OFFSET = 3'd1,
		REG_BASE   = 3'd2,
		REG_FAN    = 3'd3,
		REG_STRIP  = 3'd4
	} cfg_reg_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_PAD  = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_CMD    = 3'd0,
		PH_CNT_HI = 3'd1,
		PH_CNT_LO = 3'd2,
		PH_VTX    = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// One classified source item: up to two data bytes plus the end flag
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [1:0] cnt;
		logic       fin;
	} entry_t;

endpackage

### hdl/display_list_vertex_byte_inserter.sv
// ----------------------------------------------------------------------------
// display_list_vertex_byte_inserter
// Rewrites a display list byte stream, inserting one derived byte into each
// vertex of fan and strip draws and padding the list to the alignment.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// src      in         src_valid/src_stall  src_byte, src_final
// dst      out        dst_valid/dst_stall  dst_byte, byte_kind, dst_final
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A source item is taken every cycle while the four-entry entry queue has room.
// Each item yields zero to two data results; the last item adds up to
// ALIGN_BYTES-1 padding results or one end marker.
// The output sequencer gives one result per cycle while dst_stall is low, so the sustained rate is
// set by the results per item draining through the output register.
// Reset clears parse state, queue and output; registers take reset values.
// dst_stall holds the output register; the parser stalls only on a full queue.
// ----------------------------------------------------------------------------
module display_list_vertex_byte_inserter #(
	parameter int ALIGN_BYTES = dlvbi_pkg::ALIGN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  src_byte,
	input  logic        src_final,
	output logic        dst_valid,
	input  logic        dst_stall,
	output logic [7:0]  dst_byte,
	output logic [1:0]  byte_kind,
	output logic        dst_final,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import dlvbi_pkg::*;

	entry_t wr_ent, head;
	logic   push, pop, empty, full, accept;

	assign cfg_ready = 1'b1;
	assign src_stall = full;
	assign accept    = src_valid && !full;

	dlvbi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.src_byte  (src_byte),
		.src_final (src_final),
		.push      (push),
		.ent       (wr_ent)
	);

	dlvbi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_ent (wr_ent),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	dlvbi_back #(
		.ALIGN_BYTES (ALIGN_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_byte  (dst_byte),
		.byte_kind (byte_kind),
		.dst_final (dst_final)
	);

endmodule

### hdl/dlvbi_front.sv
// ----------------------------------------------------------------------------
// dlvbi_front
// Holds the registers, parses the source list and classifies each byte into
// a queue entry of zero to two data bytes plus the end-of-list flag.
// ----------------------------------------------------------------------------
module dlvbi_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                accept,
	input  logic [7:0]          src_byte,
	input  logic                src_final,
	output logic                push,
	output dlvbi_pkg::entry_t   ent
);
	import dlvbi_pkg::*;

	logic [7:0]  stride_q, offset_q, base_q, fan_q, strip_q;
	phase_t      phase_q, phase_d;
	logic [15:0] vl_q, vl_d;
	logic [7:0]  hi_q, hi_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  stride, off, first_cur, ins, idx_inc;
	logic [15:0] vl_dec;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RST;
			offset_q <= OFFSET_RST;
			base_q   <= BASE_RST;
			fan_q    <= FAN_RST;
			strip_q  <= STRIP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STRIDE: stride_q <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				REG_BASE:   base_q   <= cfg_data;
				REG_FAN:    fan_q    <= cfg_data;
				REG_STRIP:  strip_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			vl_q    <= '0;
			hi_q    <= '0;
			idx_q   <= '0;
			first_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			vl_q    <= vl_d;
			hi_q    <= hi_d;
			idx_q   <= idx_d;
			first_q <= first_d;
		end
	end

	// Next state and entry
	always_comb begin
		stride    = (stride_q == 8'd0) ? 8'd1 : stride_q;
		off       = (offset_q > stride) ? stride : offset_q;
		first_cur = (idx_q == 8'd0) ? src_byte : first_q;
		ins       = base_q + first_cur;
		idx_inc   = idx_q + 8'd1;
		vl_dec    = vl_q - 16'd1;

		phase_d = phase_q;
		vl_d    = vl_q;
		hi_d    = hi_q;
		idx_d   = idx_q;
		first_d = first_q;
		ent     = '0;
		ent.fin = src_final;

		unique case (phase_q)
			PH_CMD: begin
				ent.b0  = src_byte;
				ent.cnt = 2'd1;
				phase_d = (src_byte == fan_q || src_byte == strip_q) ? PH_CNT_HI : PH_DONE;
			end
			PH_CNT_HI: begin
				ent.b0  = src_byte;
				ent.cnt = 2'd1;
				hi_d    = src_byte;
				phase_d = PH_CNT_LO;
			end
			PH_CNT_LO: begin
				ent.b0  = src_byte;
				ent.cnt = 2'd1;
				vl_d    = {hi_q, src_byte};
				idx_d   = '0;
				phase_d = ({hi_q, src_byte} != 16'd0) ? PH_VTX : PH_CMD;
			end
			PH_VTX: begin
				first_d = first_cur;
				// insertion ahead of this byte
				if (idx_q == off) begin
					ent.b0  = ins;
					ent.b1  = src_byte;
					ent.cnt = 2'd2;
				end else begin
					ent.b0  = src_byte;
					ent.cnt = 2'd1;
				end
				idx_d = idx_inc;
				// end of vertex, insertion after its last byte when saturated
				if (idx_inc >= stride) begin
					if (off == stride) begin
						ent.b1  = ins;
						ent.cnt = 2'd2;
					end
					idx_d = '0;
					vl_d  = vl_dec;
					if (vl_dec == 16'd0) begin
						phase_d = PH_CMD;
					end
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		// end of list restarts parsing
		if (src_final) begin
			phase_d = PH_CMD;
			vl_d    = '0;
			hi_d    = '0;
			idx_d   = '0;
			first_d = '0;
		end
	end

	assign push = accept && (ent.cnt != 2'd0 || src_final);

endmodule

### hdl/dlvbi_queue.sv
// ----------------------------------------------------------------------------
// dlvbi_queue
// Small register FIFO of classified entries between parser and sequencer.
// ----------------------------------------------------------------------------
`include "display_list_vertex_byte_inserter_assert.svh"

module dlvbi_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dlvbi_pkg::entry_t  wr_ent,
	input  logic               pop,
	output dlvbi_pkg::entry_t  head,
	output logic               empty,
	output logic               full
);
	import dlvbi_pkg::*;

	entry_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   cnt_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));

	`DLV_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full || pop, "push into full queue")
	`DLV_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")

endmodule

### hdl/dlvbi_back.sv
// ----------------------------------------------------------------------------
// dlvbi_back
// Expands queue entries into single results: data bytes, alignment padding
// at the end of the list, or an end marker, through one output register.
// ----------------------------------------------------------------------------
`include "display_list_vertex_byte_inserter_assert.svh"

module dlvbi_back #(
	parameter int ALIGN_BYTES = dlvbi_pkg::ALIGN_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dlvbi_pkg::entry_t  head,
	input  logic               empty,
	output logic               pop,
	output logic               dst_valid,
	input  logic               dst_stall,
	output logic [7:0]         dst_byte,
	output logic [1:0]         byte_kind,
	output logic               dst_final
);
	import dlvbi_pkg::*;

	localparam int MOD_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
	localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(ALIGN_BYTES - 1);

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	kind_t             out_kind_q;
	logic              out_final_q;
	logic [MOD_W-1:0]  mod_q, mod_d, mod_inc;
	logic              pos_q, pos_d;
	logic              pad_q, pad_d;
	logic              load, emit;
	logic [7:0]        nxt_byte;
	kind_t             nxt_kind;
	logic              nxt_final;
	logic              last_data;

	assign load    = !out_valid_q || !dst_stall;
	assign emit    = load && !empty;
	assign mod_inc = (mod_q == MOD_LAST) ? '0 : mod_q + MOD_W'(1);

	// Pick the next result of the head entry
	always_comb begin
		nxt_byte  = '0;
		nxt_kind  = KIND_DATA;
		nxt_final = 1'b0;
		mod_d     = mod_q;
		pos_d     = pos_q;
		pad_d     = pad_q;
		pop       = 1'b0;
		last_data = ({1'b0, pos_q} + 2'd1) == head.cnt;
		if (!pad_q && ({1'b0, pos_q} < head.cnt)) begin
			// data byte
			nxt_byte = pos_q ? head.b1 : head.b0;
			mod_d    = mod_inc;
			if (last_data) begin
				pos_d = 1'b0;
				if (head.fin && mod_inc != '0) begin
					pad_d = 1'b1;
				end else begin
					nxt_final = head.fin;
					pop       = emit;
				end
			end else begin
				pos_d = 1'b1;
			end
		end else if (mod_q != '0) begin
			// padding up to alignment
			nxt_kind = KIND_PAD;
			mod_d    = mod_inc;
			if (mod_inc == '0) begin
				nxt_final = 1'b1;
				pad_d     = 1'b0;
				pos_d     = 1'b0;
				pop       = emit;
			end
		end else begin
			// nothing emitted for this list end
			nxt_kind  = KIND_END;
			nxt_final = 1'b1;
			pad_d     = 1'b0;
			pos_d     = 1'b0;
			pop       = emit;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
			pos_q <= 1'b0;
			pad_q <= 1'b0;
		end else if (emit) begin
			mod_q <= mod_d;
			pos_q <= pos_d;
			pad_q <= pad_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= nxt_byte;
			out_kind_q  <= nxt_kind;
			out_final_q <= nxt_final;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_byte  = out_byte_q;
	assign byte_kind = out_kind_q;
	assign dst_final = out_final_q;

	`DLV_ASSERT_IMP(a_pad_needs_mod, clk, arst_n, pad_q, mod_q != '0, "padding with aligned count")
	`DLV_ASSERT_IMP(a_end_is_final, clk, arst_n, out_valid_q && out_kind_q == KIND_END, out_final_q && out_byte_q == 8'd0, "end marker not final")

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the display list vertex byte inserter. A directed
// table of lists and register writes runs first, then random draw lists under
// several register settings. Every accepted source item is run through a
// local rewrite predictor and each output item is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
	import dlvbi_pkg::*;

	localparam int ALIGN       = ALIGN_BYTES_DEF;
	localparam int LONG_HOLD   = 300;
	localparam int WDOG_LIMIT  = 4000;
	localparam int SETTLE_CYC  = 24;
	localparam int TAIL_CYC    = 40;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 32;
	// indexes outside the register map, writes there are ignored
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	// one output item
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       fin;
	} dst_rec_t;

	// one row of the directed table: a source item or a register write
	typedef struct packed {
		logic       is_cfg;
		logic [2:0] reg_idx;
		logic [7:0] val;
		logic       fin;
		logic       typed;
		dst_rec_t   want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	logic [7:0] src_byte;
	logic       src_final;
	logic       dst_valid;
	logic       dst_stall;
	logic [7:0] dst_byte;
	logic [1:0] byte_kind;
	logic       dst_final;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	// typed expectation travels with the source payload
	logic       row_typed;
	dst_rec_t   row_exp;

	// predictor registers and parse state
	logic [7:0]  cur_stride, cur_offset, cur_base, cur_fan, cur_strip;
	phase_t      parse_ph;
	logic [15:0] verts_left;
	logic [7:0]  cnt_hi, vtx_idx, vtx_first;
	int unsigned fill_mod;

	dst_rec_t   step_bytes[$];
	dst_rec_t   rewritten_q[$];
	dir_row_t   dir_rows[$];
	logic [7:0] list_bytes[$];

	// list generator view of the current setting
	int         gen_stride;
	logic [7:0] gen_fan, gen_strip;

	bit src_on, cfg_on, quiet;
	int hold_asked, hold_served;
	int items_sent, errors, idle_cycles;

	display_list_vertex_byte_inserter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_byte  (src_byte),
		.src_final (src_final),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_byte  (dst_byte),
		.byte_kind (byte_kind),
		.dst_final (dst_final),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function void clear_parse();
		parse_ph   = PH_CMD;
		verts_left = '0;
		cnt_hi     = '0;
		vtx_idx    = '0;
		vtx_first  = '0;
		fill_mod   = 0;
	endfunction

	function void emit_byte(input logic [7:0] d, input kind_t k);
		step_bytes.push_back('{data: d, kind: k, fin: 1'b0});
		if (k != KIND_END)
			fill_mod = (fill_mod + 1) % ALIGN;
	endfunction

	// rewrite one source item into step_bytes
	function void rewrite_step(input logic [7:0] b, input logic f);
		logic [7:0] stride, off, ins;
		stride = (cur_stride == 8'd0) ? 8'd1 : cur_stride;
		off    = (cur_offset > stride) ? stride : cur_offset;
		step_bytes.delete();
		unique case (parse_ph)
			PH_CMD: begin
				emit_byte(b, KIND_DATA);
				parse_ph = (b == cur_fan || b == cur_strip) ? PH_CNT_HI : PH_DONE;
			end
			PH_CNT_HI: begin
				emit_byte(b, KIND_DATA);
				cnt_hi   = b;
				parse_ph = PH_CNT_LO;
			end
			PH_CNT_LO: begin
				emit_byte(b, KIND_DATA);
				verts_left = {cnt_hi, b};
				vtx_idx    = '0;
				parse_ph   = (verts_left != 16'd0) ? PH_VTX : PH_CMD;
			end
			PH_VTX: begin
				if (vtx_idx == 8'd0)
					vtx_first = b;
				ins = cur_base + vtx_first;
				if (vtx_idx == off)
					emit_byte(ins, KIND_DATA);
				emit_byte(b, KIND_DATA);
				vtx_idx = vtx_idx + 8'd1;
				// vertex complete; insertion after the last byte when offset saturates
				if (vtx_idx >= stride) begin
					if (off == stride)
						emit_byte(ins, KIND_DATA);
					vtx_idx    = '0;
					verts_left = verts_left - 16'd1;
					if (verts_left == 16'd0)
						parse_ph = PH_CMD;
				end
			end
			default: parse_ph = PH_DONE;
		endcase
		// end of list: pad, or a lone end marker
		if (f) begin
			while (fill_mod != 0)
				emit_byte(8'd0, KIND_PAD);
			if (step_bytes.size() == 0)
				emit_byte(8'd0, KIND_END);
			step_bytes[step_bytes.size() - 1].fin = 1'b1;
			clear_parse();
		end
	endfunction

	// ---------------- scoreboard and watchdog ----------------

	always @(posedge clk) begin : score
		dst_rec_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n === 1'b1) begin
			if (cfg_valid && cfg_ready === 1'b1) begin
				moved = 1'b1;
				unique case (cfg_index)
					REG_STRIDE: cur_stride = cfg_data;
					REG_OFFSET: cur_offset = cfg_data;
					REG_BASE:   cur_base   = cfg_data;
					REG_FAN:    cur_fan    = cfg_data;
					REG_STRIP:  cur_strip  = cfg_data;
					default: ;
				endcase
			end
			if (src_valid && src_stall === 1'b0) begin
				moved = 1'b1;
				rewrite_step(src_byte, src_final);
				if (row_typed)
					rewritten_q.push_back(row_exp);
				else
					foreach (step_bytes[k])
						rewritten_q.push_back(step_bytes[k]);
			end
			if (dst_valid === 1'b1 && !dst_stall) begin
				moved = 1'b1;
				if (rewritten_q.size() == 0) begin
					$error("unexpected item: dst_byte %02h byte_kind %0d dst_final %0b",
						dst_byte, byte_kind, dst_final);
					errors++;
				end else begin
					want = rewritten_q.pop_front();
					if (dst_byte !== want.data) begin
						$error("dst_byte: expected %02h, got %02h", want.data, dst_byte);
						errors++;
					end
					if (byte_kind !== want.kind) begin
						$error("byte_kind: expected %0d, got %0d", want.kind, byte_kind);
						errors++;
					end
					if (dst_final !== want.fin) begin
						$error("dst_final: expected %0b, got %0b", want.fin, dst_final);
						errors++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("display_list_vertex_byte_inserter verification failed");
				$finish;
			end
		end
	end

	// ---------------- receiver ----------------

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	initial begin : drain_side
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				// long hold-off so the block backs up into the source side
				hold_served = hold_asked;
				dst_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				stall_left = 0;
			end else if (stall_left > 0) begin
				stall_left--;
				dst_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < 25) begin
				stall_left = idle_len() - 1;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= 1'b0;
			end
		end
	end

	// ---------------- sender helpers ----------------

	task automatic src_idle();
		if (src_on) begin
			src_valid <= 1'b0;
			src_on = 1'b0;
		end
	endtask

	task automatic cfg_idle();
		if (cfg_on) begin
			cfg_valid <= 1'b0;
			cfg_on = 1'b0;
		end
	endtask

	// offer one item and hold it until taken; valid stays up for a back-to-back item
	task automatic put_src(input logic [7:0] b, input logic f, input logic typed,
		input dst_rec_t want);
		int gap;
		gap = (quiet || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
		if (gap > 0) begin
			src_idle();
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_byte  <= b;
		src_final <= f;
		row_typed <= typed;
		row_exp   <= want;
		src_on = 1'b1;
		items_sent++;
		do @(posedge clk); while (src_stall !== 1'b0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_on = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	// wait for every expected item, always stepping the clock before the first check
	task automatic drain();
		do @(posedge clk); while (rewritten_q.size() != 0);
	endtask

	// idle the block before touching registers; dropped items may still be in flight
	task automatic settle();
		src_idle();
		drain();
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	function automatic dir_row_t src_in(input logic [7:0] b, input logic f);
		dir_row_t r;
		r = '0;
		r.val = b;
		r.fin = f;
		return r;
	endfunction

	function automatic dir_row_t src_exp(input logic [7:0] b, input logic f,
		input logic [7:0] d, input kind_t k, input logic ef);
		dir_row_t r;
		r = src_in(b, f);
		r.typed = 1'b1;
		r.want  = '{data: d, kind: k, fin: ef};
		return r;
	endfunction

	function automatic dir_row_t reg_wr(input cfg_reg_t idx, input logic [7:0] d);
		dir_row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.val     = d;
		return r;
	endfunction

	// build one random list and send it, last byte flagged final
	task automatic send_list();
		int ncmd, nvtx, keep;
		logic [7:0] op, t;
		logic [15:0] cnt;
		bit big;
		list_bytes.delete();
		big = 1'b0;
		if ($urandom_range(0, 9) == 0) begin
			// noise
			repeat ($urandom_range(1, 6))
				list_bytes.push_back(8'($urandom));
		end else begin
			ncmd = $urandom_range(1, 3);
			for (int c = 0; c < ncmd && !big; c++) begin
				op = $urandom_range(0, 1) ? gen_fan : gen_strip;
				if ($urandom_range(0, 19) == 0) begin
					cnt = {8'($urandom_range(1, 255)), 8'($urandom)};
					big = 1'b1;
				end else if (gen_stride > 16) begin
					cnt = 16'($urandom_range(0, 1));
				end else begin
					cnt = 16'($urandom_range(0, 4));
				end
				list_bytes.push_back(op);
				list_bytes.push_back(cnt[15:8]);
				list_bytes.push_back(cnt[7:0]);
				nvtx = big ? $urandom_range(0, 2) : int'(cnt);
				repeat (nvtx * gen_stride)
					list_bytes.push_back(8'($urandom));
			end
			if (big) begin
				// huge count: the list ends inside the vertex data
				repeat ($urandom_range(0, gen_stride - 1))
					list_bytes.push_back(8'($urandom));
			end else if ($urandom_range(0, 9) < 7) begin
				// closing non-draw command, then bytes that get dropped
				do t = 8'($urandom); while (t == gen_fan || t == gen_strip);
				list_bytes.push_back(t);
				repeat ($urandom_range(0, 3))
					list_bytes.push_back(8'($urandom));
			end
			// broken list: cut short
			if (list_bytes.size() > 1 &&
				$urandom_range(0, 99) < (gen_stride > 16 ? 75 : 15)) begin
				keep = $urandom_range(1, list_bytes.size() - 1);
				while (list_bytes.size() > keep)
					void'(list_bytes.pop_back());
			end
		end
		foreach (list_bytes[i])
			put_src(list_bytes[i], i == list_bytes.size() - 1, 1'b0, '0);
	endtask

	// ---------------- stimulus ----------------

	initial begin : stimulus
		dir_row_t row;
		int start;
		logic [7:0] v_stride, v_off, v_base, v_fan, v_strip;

		src_valid <= 1'b0;
		src_byte  <= '0;
		src_final <= 1'b0;
		row_typed <= 1'b0;
		row_exp   <= '0;
		dst_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		cur_stride = STRIDE_RST;
		cur_offset = OFFSET_RST;
		cur_base   = BASE_RST;
		cur_fan    = FAN_RST;
		cur_strip  = STRIP_RST;
		clear_parse();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lists, reset setting first
		dir_rows = '{
			// fan with 14 one-byte vertices, 32 bytes out, then a dropped final byte
			src_exp(8'hA0, 1'b0, 8'hA0, KIND_DATA, 1'b0),
			src_exp(8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0),
			src_exp(8'h0E, 1'b0, 8'h0E, KIND_DATA, 1'b0),
			src_in(8'h00, 1'b0), src_in(8'hFF, 1'b0), src_in(8'h01, 1'b0),
			src_in(8'h80, 1'b0), src_in(8'h7F, 1'b0), src_in(8'h55, 1'b0),
			src_in(8'hAA, 1'b0), src_in(8'h10, 1'b0), src_in(8'h20, 1'b0),
			src_in(8'h40, 1'b0), src_in(8'h08, 1'b0), src_in(8'h04, 1'b0),
			src_in(8'hC3, 1'b0), src_in(8'h3C, 1'b0),
			src_exp(8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0),
			src_exp(8'hFF, 1'b1, 8'h00, KIND_END, 1'b1),
			// strip with zero vertices, then maximum count cut short
			src_exp(8'h98, 1'b0, 8'h98, KIND_DATA, 1'b0),
			src_in(8'h00, 1'b0), src_in(8'h00, 1'b0),
			src_in(8'h98, 1'b0), src_in(8'hFF, 1'b0), src_in(8'hFF, 1'b0),
			src_in(8'h7F, 1'b1),
			// offset above stride, same opcode for fan and strip, base at max
			reg_wr(REG_STRIDE, 8'd3),
			reg_wr(REG_OFFSET, 8'd200),
			reg_wr(REG_BASE, 8'hFF),
			reg_wr(REG_FAN, 8'h00),
			reg_wr(REG_STRIP, 8'h00),
			src_in(8'h00, 1'b0), src_in(8'h00, 1'b0), src_in(8'h01, 1'b0),
			src_in(8'h80, 1'b0), src_in(8'h01, 1'b0), src_in(8'h02, 1'b1)
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				if (src_on)
					settle();
				write_reg(row.reg_idx, row.val);
			end else begin
				cfg_idle();
				put_src(row.val, row.fin, row.typed, row.want);
			end
		end

		// random lists under a run of register settings
		for (int p = 0; p < PHASES; p++) begin
			settle();
			v_base = 8'($urandom);
			unique case (p)
				0: begin
					v_stride = 8'd0;
					v_off    = 8'd0;
					v_fan    = 8'($urandom);
					v_strip  = 8'($urandom);
				end
				1: begin
					// long vertices with the offset saturated to the stride
					v_stride = 8'd48;
					v_off    = 8'd255;
					v_base   = 8'd255;
					v_fan    = 8'd255;
					v_strip  = 8'd0;
				end
				2: begin
					v_stride = 8'd2;
					v_off    = 8'd1;
					v_fan    = FAN_RST;
					v_strip  = STRIP_RST;
				end
				3: begin
					v_stride = 8'($urandom_range(1, 8));
					v_off    = 8'($urandom_range(0, 12));
					v_fan    = 8'($urandom);
					v_strip  = v_fan;
				end
				default: begin
					v_stride = 8'($urandom_range(1, 12));
					v_off    = 8'($urandom_range(0, 15));
					v_fan    = 8'($urandom);
					v_strip  = 8'($urandom);
				end
			endcase
			write_reg(REG_STRIDE, v_stride);
			write_reg(REG_OFFSET, v_off);
			write_reg(REG_BASE, v_base);
			write_reg(REG_FAN, v_fan);
			write_reg(REG_STRIP, v_strip);
			if (p == 0) begin
				write_reg(REG_UNUSED_LO, 8'hFF);
				write_reg(REG_UNUSED_HI, 8'h00);
			end
			cfg_idle();
			gen_stride = (v_stride == 8'd0) ? 1 : int'(v_stride);
			gen_fan    = v_fan;
			gen_strip  = v_strip;
			quiet      = (p == 2 || p == 5);
			if (p == 2)
				hold_asked++;
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				send_list();
				// now and then let the block run dry between lists
				if ($urandom_range(0, 9) == 0) begin
					src_idle();
					drain();
				end
			end
		end
		quiet = 1'b0;

		src_idle();
		drain();
		repeat (TAIL_CYC) @(posedge clk);
		if (errors == 0)
			$display("display_list_vertex_byte_inserter verification clean");
		else
			$display("display_list_vertex_byte_inserter verification failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/dlvbi_pkg.sv
hdl/dlvbi_front.sv
hdl/dlvbi_queue.sv
hdl/dlvbi_back.sv
hdl/display_list_vertex_byte_inserter.sv
sim/tb_top.sv
